/* design/cor_pkg.sv */
// Shared constants and types for the co-occurrence ranker.
package cor_pkg;
	localparam int MAX_ITEMS  = 64;
	localparam int ID_BITS    = 6;
	localparam int COUNT_BITS = 16;
	localparam int MEM_DEPTH  = MAX_ITEMS * MAX_ITEMS;
	localparam int ADDR_BITS  = 2 * ID_BITS;
	localparam int CAND_BITS  = ID_BITS + 1;

	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [CAND_BITS-1:0]  cand_t;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_REL  = 2'd1;
	localparam logic [1:0] OP_RANK = 2'd2;

	localparam id_t ID_LAST = id_t'(MAX_ITEMS - 1);
endpackage

/* design/cor_ram.sv */
// Generic single-port synchronous RAM with registered read.
module cor_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* design/co_occurrence_ranker.sv */
// Co-occurrence ranker top level: control, presence map and count memory.
// The pair counts live in one single-port memory that uses one cell per unordered
// pair, so the block performs one memory access per cycle. An add is accepted,
// then one write per id clears the row and column; a relate is accepted, read,
// then written back with saturation; a request runs one scan per result plus a
// drain and an emit state and any wait for the output beat handshake.
// No reset clearing pass is needed: a cell is read only when both of
// its ids are present, and it was cleared when the later of the two was added.
// Items are handled one at a time.
module co_occurrence_ranker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [cor_pkg::ID_BITS-1:0]    item_id,
	input  logic [cor_pkg::ID_BITS-1:0]    related_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cor_pkg::ID_BITS-1:0]    ranked_id,
	output logic [cor_pkg::COUNT_BITS-1:0] pair_count,
	output logic                       none_found,
	output logic                       last
);
	import cor_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLR   = 3'd1;
	localparam logic [2:0] ST_RDRD  = 3'd2;
	localparam logic [2:0] ST_RDWR  = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]           state_q;
	id_t                  a_q, b_q, idx_q;
	logic [MAX_ITEMS-1:0] present_q, emitted_q;
	logic                 a_present_q;
	logic                 vld_s1, cand_s1;
	id_t                  id_s1;
	logic                 best_vld_q;
	id_t                  best_id_q;
	count_t               best_cnt_q;
	cand_t                ncand_q;
	logic                 out_valid_q, none_q, last_q;
	id_t                  out_id_q;
	count_t               out_cnt_q;

	logic   mem_we;
	id_t    peer, lo, hi;
	addr_t  mem_addr;
	count_t mem_wdata, mem_rdata, inc, cnt_s1;
	logic   cand, out_free;

	cor_ram #(.WIDTH(COUNT_BITS), .DEPTH(MEM_DEPTH)) u_counts (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_comb begin
		peer      = (state_q == ST_CLR || state_q == ST_SCAN) ? idx_q : b_q;
		lo        = (a_q < peer) ? a_q : peer;
		hi        = (a_q < peer) ? peer : a_q;
		mem_addr  = {lo, hi};
		inc       = (mem_rdata == '1) ? mem_rdata : mem_rdata + count_t'(1);
		mem_we    = (state_q == ST_CLR) || (state_q == ST_RDWR);
		mem_wdata = (state_q == ST_CLR) ? '0 : inc;
		cand      = present_q[idx_q] && (idx_q != a_q) && !emitted_q[idx_q];
		cnt_s1    = a_present_q ? mem_rdata : '0;
		out_free  = !out_valid_q || out_ready;
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign ranked_id  = out_id_q;
	assign pair_count = out_cnt_q;
	assign none_found = none_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= '0;
			emitted_q   <= '0;
			vld_s1      <= 1'b0;
			best_vld_q  <= 1'b0;
			ncand_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;
			vld_s1 <= (state_q == ST_SCAN);
			id_s1  <= idx_q;
			cand_s1 <= cand;
			if (vld_s1 && cand_s1) begin
				ncand_q <= ncand_q + cand_t'(1);
				if (!best_vld_q || cnt_s1 > best_cnt_q) begin
					best_vld_q <= 1'b1;
					best_id_q  <= id_s1;
					best_cnt_q <= cnt_s1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						a_q         <= item_id;
						b_q         <= related_id;
						a_present_q <= present_q[item_id];
						idx_q       <= '0;
						emitted_q   <= '0;
						best_vld_q  <= 1'b0;
						ncand_q     <= '0;
						priority if (op == OP_ADD && item_id != '0) begin
							state_q <= ST_CLR;
						end else if (op == OP_REL && item_id != '0 && related_id != '0
							&& item_id != related_id && present_q[item_id]
							&& present_q[related_id]) begin
							state_q <= ST_RDRD;
						end else if (op == OP_RANK) begin
							idx_q   <= id_t'(1);
							state_q <= (item_id != '0) ? ST_SCAN : ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLR: begin
					idx_q <= idx_q + id_t'(1);
					if (idx_q == ID_LAST) begin
						present_q[a_q] <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_RDRD: state_q <= ST_RDWR;
				ST_RDWR: state_q <= ST_IDLE;
				ST_SCAN: begin
					idx_q <= idx_q + id_t'(1);
					if (idx_q == ID_LAST)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (ncand_q == '0) begin
							out_id_q <= '0;
							out_cnt_q <= '0;
							none_q   <= 1'b1;
							last_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							out_id_q             <= best_id_q;
							out_cnt_q            <= best_cnt_q;
							none_q               <= 1'b0;
							last_q               <= (ncand_q == cand_t'(1));
							emitted_q[best_id_q] <= 1'b1;
							best_vld_q           <= 1'b0;
							ncand_q              <= '0;
							idx_q                <= id_t'(1);
							state_q <= (ncand_q == cand_t'(1)) ? ST_IDLE : ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLR || state_q == ST_RDWR))
		else $error("count memory written outside clear or relate");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && none_q) |-> (last_q && out_id_q == '0))
		else $error("none-found beat malformed");

	a_real_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !none_q) |-> (out_id_q != '0 && (last_q || out_id_q != a_q)))
		else $error("ranked id is zero or the requested id");

	a_best_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && ncand_q != '0) |-> (best_vld_q && !emitted_q[best_id_q]))
		else $error("emit without a fresh best candidate");
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the co-occurrence ranker: random-gap driver, stalling monitor.
module tb;
	import cor_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		id_t        a;
		id_t        b;
	} cmd_t;

	typedef struct packed {
		id_t    rid;
		count_t cnt;
		logic   nf;
		logic   lst;
	} rank_t;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_ADD;
	id_t item_id = '0;
	id_t related_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	id_t ranked_id;
	count_t pair_count;
	logic none_found;
	logic last;

	cmd_t cmd_q[$];
	rank_t ranking_q[$];
	count_t counts[MAX_ITEMS][MAX_ITEMS];
	bit present[MAX_ITEMS];
	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit hold_for_drain = 1'b0;

	co_occurrence_ranker dut (.*);

	always #4 clk = ~clk;

	function automatic bit usable(id_t id);
		return id != 0;
	endfunction

	function automatic void add_cmd(cmd_t c);
		cmd_q = {cmd_q, c};
	endfunction

	function automatic void queue_beat(rank_t r);
		ranking_q = {ranking_q, r};
	endfunction

	task automatic predict_ranking(cmd_t c);
		id_t ids[$];
		count_t cv[$];
		int k;
		rank_t r;
		if (c.op == OP_ADD) begin
			if (usable(c.a)) begin
				for (int i = 0; i < MAX_ITEMS; i++) begin
					counts[c.a][i] = '0;
					counts[i][c.a] = '0;
				end
				present[c.a] = 1'b1;
			end
		end else if (c.op == OP_REL) begin
			if (usable(c.a) && usable(c.b) && c.a != c.b && present[c.a] && present[c.b]) begin
				if (counts[c.a][c.b] != '1) counts[c.a][c.b]++;
				if (counts[c.b][c.a] != '1) counts[c.b][c.a]++;
			end
		end else if (c.op == OP_RANK) begin
			if (usable(c.a)) begin
				for (int i = 1; i < MAX_ITEMS; i++) begin
					if (i != c.a && present[i]) begin
						k = ids.size();
						while (k > 0 && cv[k-1] < counts[c.a][i]) k--;
						ids.insert(k, id_t'(i));
						cv.insert(k, counts[c.a][i]);
					end
				end
			end
			if (ids.size() == 0) begin
				r = '{rid: '0, cnt: '0, nf: 1'b1, lst: 1'b1};
				queue_beat(r);
			end else begin
				foreach (ids[j]) begin
					r = '{rid: ids[j], cnt: cv[j], nf: 1'b0, lst: j == ids.size() - 1};
					queue_beat(r);
				end
			end
		end
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		cmd_t c;
		if (in_valid && in_ready) begin
			predict_ranking('{op: op, a: item_id, b: related_id});
			in_valid <= 1'b0;
			send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
		end else if (!in_valid && arst_n) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (cmd_q.size() > 0) begin
				c = cmd_q[0];
				if (c.op == OP_UNUSED && c.a == '1 && c.b == '1 && !hold_for_drain) begin
					// drain marker: wait for every expected beat
					hold_for_drain <= 1'b1;
				end else if (hold_for_drain) begin
					if (ranking_q.size() == 0) begin
						void'(cmd_q.pop_front());
						hold_for_drain <= 1'b0;
					end
				end else begin
					void'(cmd_q.pop_front());
					op <= c.op;
					item_id <= c.a;
					related_id <= c.b;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rank_t e;
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (ranking_q.size() == 0) begin
				report("unexpected beat ranked_id", ranked_id, -1);
			end else begin
				e = ranking_q.pop_front();
				if (ranked_id !== e.rid) report("ranked_id", ranked_id, e.rid);
				if (pair_count !== e.cnt) report("pair_count", pair_count, e.cnt);
				if (none_found !== e.nf) report("none_found", none_found, e.nf);
				if (last !== e.lst) report("last", last, e.lst);
			end
			out_ready <= 1'b0;
			recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
		end else if (!out_ready && arst_n) begin
			if (recv_gap > 0) recv_gap <= recv_gap - 1;
			else out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic id_t pick_id();
		return $urandom_range(0, 9) == 0 ? id_t'($urandom) : id_t'($urandom_range(1, 12));
	endfunction

	initial begin
		cmd_t c;
		id_t hot;
		int n;
		foreach (present[i]) present[i] = 1'b0;
		foreach (counts[i, j]) counts[i][j] = '0;
		// directed: empty ranking, id zero, self and absent relates, extremes
		add_cmd('{OP_RANK, id_t'(5), id_t'(0)});
		add_cmd('{OP_RANK, id_t'(0), id_t'(63)});
		add_cmd('{OP_ADD, id_t'(0), id_t'(0)});
		add_cmd('{OP_ADD, ID_LAST, id_t'(0)});
		add_cmd('{OP_RANK, ID_LAST, id_t'(0)});
		add_cmd('{OP_ADD, id_t'(1), id_t'(42)});
		add_cmd('{OP_REL, id_t'(1), ID_LAST});
		add_cmd('{OP_REL, ID_LAST, id_t'(1)});
		add_cmd('{OP_REL, id_t'(1), id_t'(1)});
		add_cmd('{OP_REL, id_t'(1), id_t'(2)});
		add_cmd('{OP_REL, id_t'(0), id_t'(1)});
		add_cmd('{OP_UNUSED, id_t'(1), ID_LAST});
		add_cmd('{OP_ADD, id_t'(42), id_t'(21)});
		add_cmd('{OP_RANK, id_t'(1), id_t'(0)});
		add_cmd('{OP_RANK, id_t'(2), id_t'(0)});
		add_cmd('{OP_ADD, ID_LAST, id_t'(0)});
		add_cmd('{OP_RANK, id_t'(1), id_t'(0)});
		add_cmd('{OP_UNUSED, '1, '1});
		add_cmd('{OP_RANK, id_t'(42), id_t'(0)});
		// random: mixed adds, relates, rankings and unused ops, then a burst of relates around a hot id and its ranking
		for (int i = 0; i < 70; i++) begin
			n = $urandom_range(0, 9);
			if (n < 2) c = '{OP_ADD, pick_id(), id_t'($urandom)};
			else if (n < 7) c = '{OP_REL, pick_id(), pick_id()};
			else if (n < 9) c = '{OP_RANK, pick_id(), id_t'($urandom)};
			else c = '{2'($urandom), id_t'($urandom), id_t'($urandom)};
			add_cmd(c);
			if (i == 35) add_cmd('{OP_UNUSED, '1, '1});
		end
		hot = id_t'($urandom_range(1, 12));
		for (int i = 0; i < 12; i++)
			add_cmd('{OP_REL, hot, id_t'($urandom_range(1, 12))});
		add_cmd('{OP_RANK, hot, id_t'(0)});
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk);
		while (cmd_q.size() != 0 || in_valid || ranking_q.size() != 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
